@@ rtl/usv_pkg.sv @@
// Package for the UTF-8 stream validator: field widths, byte masks and
// code point limits used by the validator and its port checker.
// Depends on nothing.
package usv_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int OUT_W             = 32;
  localparam int OFFSET_W          = 33;
  localparam int CP_W              = 21;

  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] CODE_CONT  = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] CODE_LEAD2 = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] CODE_LEAD3 = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] CODE_LEAD4 = 8'hF0;
  localparam logic [4:0] LEAD2_MIN  = 5'h02;

  localparam logic [2:0] SEQ_LEN_2 = 3'd2;
  localparam logic [2:0] SEQ_LEN_3 = 3'd3;
  localparam logic [2:0] SEQ_LEN_4 = 3'd4;

  localparam logic [CP_W-1:0] CP_MIN_3      = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_4      = 21'h010000;
  localparam logic [CP_W-1:0] CP_SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI    = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;

endpackage

@@ rtl/utf8_stream_validator.sv @@
// UTF-8 stream validator. A last byte is held in the input register, then its
// result is registered in the result register and shown on out_valid.
// Throughput: one byte per cycle; a last byte waits in the input register
// only while an earlier result is still held unaccepted in the result register.
// Reset (rst_n low at a rising edge) empties both registers and clears the
// decoder state; the block accepts bytes from the first cycle after reset.
// Depends on usv_pkg.
module utf8_stream_validator #(
  parameter int POSITION_BITS = usv_pkg::POSITION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 in_last_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_is_valid,
  output logic signed [usv_pkg::OFFSET_W-1:0]  out_bad_offset,
  output logic [usv_pkg::OUT_W-1:0]            out_codepoint_count
);
  import usv_pkg::*;

  localparam int P = POSITION_BITS;
  localparam logic [P-1:0] POS_MAX = {P{1'b1}};

  logic                s1_valid_r;
  logic [7:0]          s1_byte_r;
  logic                s1_last_r;
  logic                s1_adv;

  logic [P-1:0]        pos_r, pos_nxt;
  logic [P-1:0]        start_r, start_nxt;
  logic [1:0]          pend_r, pend_nxt;
  logic [2:0]          len_r, len_nxt;
  logic [CP_W-1:0]     part_r, part_nxt;
  logic                err_r, err_nxt;
  logic [P-1:0]        err_off_r, err_off_nxt;
  logic [P-1:0]        lead_r, lead_nxt;

  logic                cont;
  logic [CP_W-1:0]     cp_shift;
  logic                cp_bad;
  logic [OUT_W-1:0]    off_clamp;
  logic [OUT_W-1:0]    cnt_clamp;

  logic                out_valid_r;
  logic                out_is_valid_r;
  logic [OFFSET_W-1:0] out_bad_offset_r;
  logic [OUT_W-1:0]    out_count_r;

  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  assign cont     = (s1_byte_r & MASK_CONT) == CODE_CONT;
  assign cp_shift = {part_r[CP_W-7:0], s1_byte_r[5:0]};
  assign cp_bad   = (len_r == SEQ_LEN_3 && cp_shift < CP_MIN_3)
                 || (len_r == SEQ_LEN_4 && cp_shift < CP_MIN_4)
                 || (cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI)
                 || (cp_shift > CP_MAX);

  always_comb begin
    pos_nxt     = (pos_r == POS_MAX) ? pos_r : pos_r + P'(1);
    start_nxt   = start_r;
    pend_nxt    = pend_r;
    len_nxt     = len_r;
    part_nxt    = part_r;
    err_nxt     = err_r;
    err_off_nxt = err_off_r;
    lead_nxt    = (cont || lead_r == POS_MAX) ? lead_r : lead_r + P'(1);
    if (!err_r) begin
      if (pend_r != 2'd0) begin
        if (!cont) begin
          err_nxt     = 1'b1;
          err_off_nxt = start_r;
          pend_nxt    = 2'd0;
        end else begin
          part_nxt = cp_shift;
          pend_nxt = pend_r - 2'd1;
          if (pend_r == 2'd1 && cp_bad) begin
            err_nxt     = 1'b1;
            err_off_nxt = start_r;
          end
        end
      end else begin
        priority if (!s1_byte_r[7]) begin
          pend_nxt = 2'd0;
        end else if ((s1_byte_r & MASK_LEAD2) == CODE_LEAD2) begin
          if (s1_byte_r[4:0] < LEAD2_MIN) begin
            err_nxt     = 1'b1;
            err_off_nxt = pos_r;
          end else begin
            start_nxt = pos_r;
            len_nxt   = SEQ_LEN_2;
            pend_nxt  = 2'd1;
            part_nxt  = CP_W'(s1_byte_r[4:0]);
          end
        end else if ((s1_byte_r & MASK_LEAD3) == CODE_LEAD3) begin
          start_nxt = pos_r;
          len_nxt   = SEQ_LEN_3;
          pend_nxt  = 2'd2;
          part_nxt  = CP_W'(s1_byte_r[3:0]);
        end else if ((s1_byte_r & MASK_LEAD4) == CODE_LEAD4) begin
          start_nxt = pos_r;
          len_nxt   = SEQ_LEN_4;
          pend_nxt  = 2'd3;
          part_nxt  = CP_W'(s1_byte_r[2:0]);
        end else begin
          err_nxt     = 1'b1;
          err_off_nxt = pos_r;
        end
      end
    end
    if (s1_last_r && !err_nxt && pend_nxt != 2'd0) begin
      err_nxt     = 1'b1;
      err_off_nxt = start_nxt;
    end
  end

  generate
    if (P > OUT_W) begin : g_wide
      assign off_clamp = (|err_off_nxt[P-1:OUT_W]) ? '1 : err_off_nxt[OUT_W-1:0];
      assign cnt_clamp = (|lead_nxt[P-1:OUT_W]) ? '1 : lead_nxt[OUT_W-1:0];
    end else begin : g_narrow
      assign off_clamp = OUT_W'(err_off_nxt);
      assign cnt_clamp = OUT_W'(lead_nxt);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      start_r   <= '0;
      pend_r    <= '0;
      len_r     <= '0;
      part_r    <= '0;
      err_r     <= 1'b0;
      err_off_r <= '0;
      lead_r    <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        pos_r     <= '0;
        start_r   <= '0;
        pend_r    <= '0;
        len_r     <= '0;
        part_r    <= '0;
        err_r     <= 1'b0;
        err_off_r <= '0;
        lead_r    <= '0;
      end else begin
        pos_r     <= pos_nxt;
        start_r   <= start_nxt;
        pend_r    <= pend_nxt;
        len_r     <= len_nxt;
        part_r    <= part_nxt;
        err_r     <= err_nxt;
        err_off_r <= err_off_nxt;
        lead_r    <= lead_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_is_valid_r   <= !err_nxt;
      out_bad_offset_r <= err_nxt ? {1'b0, off_clamp} : '1;
      out_count_r      <= cnt_clamp;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_is_valid        = out_is_valid_r;
  assign out_bad_offset      = $signed(out_bad_offset_r);
  assign out_codepoint_count = out_count_r;

endmodule

@@ rtl/usv_checker.sv @@
// Port-level checker for the UTF-8 stream validator, with its bind.
// Depends on usv_pkg and the utf8_stream_validator port list.
module usv_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_is_valid,
  input logic signed [usv_pkg::OFFSET_W-1:0] out_bad_offset,
  input logic [usv_pkg::OUT_W-1:0]           out_codepoint_count
);
  import usv_pkg::*;

  localparam logic [OFFSET_W-1:0] OFFSET_NONE = '1;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_valid)
      && $stable(out_bad_offset) && $stable(out_codepoint_count))
    else $error("Result item changed while stalled.");

  a_valid_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_valid |-> out_bad_offset == $signed(OFFSET_NONE))
    else $error("A valid string reported a bad offset.");

  a_bad_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_valid |-> !out_bad_offset[OFFSET_W-1])
    else $error("An invalid string reported a negative offset.");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_codepoint_count == '0 |-> !out_is_valid)
    else $error("A string with no lead bytes was reported valid.");

endmodule

bind utf8_stream_validator usv_checker u_usv_checker (.*);
